// ===== src/psch_pkg.sv =====
// Shared types, constants and record builders of the priority scheduler.
// No dependencies; every other file of the block imports this package.
package psch_pkg;

   localparam int MAX_PROCS = 16;
   localparam int IDX_W     = $clog2(MAX_PROCS);
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);
   localparam int TIME_W    = 16;
   localparam int PRI_W     = 8;
   localparam int TICK_W    = 21;
   localparam int SUM_W     = 25;
   localparam int PIDX_W    = 4;

   typedef enum logic [1:0] {
      KIND_SEG = 2'd0,
      KIND_MET = 2'd1,
      KIND_TOT = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DECIDE,
      ST_SEG,
      ST_MET,
      ST_IDLE_SEG,
      ST_SWITCH,
      ST_RUN,
      ST_FLUSH,
      ST_MRD,
      ST_MEMIT,
      ST_TOTAL
   } state_type;

   // one process table row
   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [PRI_W-1:0]  priority_num;
      logic [TIME_W-1:0] remaining;
      logic [TICK_W-1:0] first_run;
      logic [TICK_W-1:0] finish;
   } entry_type;

   // table port controls from the sequencer
   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      entry_type         wdata;
      logic              re;
      logic [IDX_W-1:0]  raddr;
   } mem_req_type;

   typedef struct packed {
      kind_type          kind;
      logic [PIDX_W-1:0] proc_index;
      logic [TICK_W-1:0] seg_start;
      logic [TICK_W-1:0] seg_end;
      logic [TIME_W-1:0] arrival_echo;
      logic [TIME_W-1:0] burst_echo;
      logic [PRI_W-1:0]  priority_echo;
      logic [TICK_W-1:0] finish_tick;
      logic [SUM_W-1:0]  turnaround;
      logic [SUM_W-1:0]  waiting;
      logic [SUM_W-1:0]  response;
      logic              end_of_run;
   } rsp_type;

   function automatic rsp_type seg_rec(logic [IDX_W-1:0] idx, logic [TICK_W-1:0] s,
                                       logic [TICK_W-1:0] e);
      rsp_type r;
      r            = '0;
      r.kind       = KIND_SEG;
      r.proc_index = PIDX_W'(idx);
      r.seg_start  = s;
      r.seg_end    = e;
      return r;
   endfunction

   function automatic rsp_type met_rec(logic [IDX_W-1:0] idx, entry_type e);
      rsp_type r;
      logic [SUM_W-1:0] tat;
      tat               = SUM_W'(e.finish) - SUM_W'(e.arrival);
      r                 = '0;
      r.kind            = KIND_MET;
      r.proc_index      = PIDX_W'(idx);
      r.seg_start       = e.first_run;
      r.arrival_echo    = e.arrival;
      r.burst_echo      = e.burst;
      r.priority_echo   = e.priority_num;
      r.finish_tick     = e.finish;
      r.turnaround      = tat;
      r.waiting         = tat - SUM_W'(e.burst);
      r.response        = SUM_W'(e.first_run) - SUM_W'(e.arrival);
      return r;
   endfunction

   function automatic rsp_type tot_rec(logic [SUM_W-1:0] tat, logic [SUM_W-1:0] wt,
                                       logic [SUM_W-1:0] rs);
      rsp_type r;
      r            = '0;
      r.kind       = KIND_TOT;
      r.turnaround = tat;
      r.waiting    = wt;
      r.response   = rs;
      r.end_of_run = 1'b1;
      return r;
   endfunction

endpackage

// ===== src/psch_if.sv =====
// Channel interfaces of the priority scheduler: load, result and register write.
// Depends on psch_pkg for field widths and the record kind type.
interface psch_req_if;
   import psch_pkg::*;
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] arrival_tick;
   logic [TIME_W-1:0] burst_len;
   logic [PRI_W-1:0]  priority_req;
   logic              last;
   modport source (output valid, arrival_tick, burst_len, priority_req, last, input ready);
   modport sink   (input valid, arrival_tick, burst_len, priority_req, last, output ready);
endinterface

interface psch_rsp_if;
   import psch_pkg::*;
   logic              valid;
   logic              ready;
   kind_type          kind;
   logic [PIDX_W-1:0] proc_index;
   logic [TICK_W-1:0] seg_start;
   logic [TICK_W-1:0] seg_end;
   logic [TIME_W-1:0] arrival_echo;
   logic [TIME_W-1:0] burst_echo;
   logic [PRI_W-1:0]  priority_echo;
   logic [TICK_W-1:0] finish_tick;
   logic [SUM_W-1:0]  turnaround;
   logic [SUM_W-1:0]  waiting;
   logic [SUM_W-1:0]  response;
   logic              end_of_run;
   modport source (output valid, kind, proc_index, seg_start, seg_end, arrival_echo,
                   burst_echo, priority_echo, finish_tick, turnaround, waiting,
                   response, end_of_run, input ready);
   modport sink   (input valid, kind, proc_index, seg_start, seg_end, arrival_echo,
                   burst_echo, priority_echo, finish_tick, turnaround, waiting,
                   response, end_of_run, output ready);
endinterface

interface psch_csr_if;
   logic valid;
   logic ready;
   logic preemptive_mode;
   modport source (output valid, preemptive_mode, input ready);
   modport sink   (input valid, preemptive_mode, output ready);
endinterface

// ===== src/psch_table.sv =====
// Process table: one synchronous RAM row per loaded process, registered read.
// Depends on psch_pkg for the row and port control types.
module psch_table
   import psch_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mreq,
   output entry_type   rd_data
);

   entry_type mem [MAX_PROCS];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mreq.we) begin
         mem[mreq.waddr] <= mreq.wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (mreq.re) begin
         rd_data_ff <= mem[mreq.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/psch_obuf.sv =====
// Result output register: holds one record beat while the sink stalls.
// Depends on psch_pkg and the result channel interface.
module psch_obuf
   import psch_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       emit_valid,
   input  rsp_type    emit_rec,
   output logic       emit_ready,
   psch_rsp_if.source rsp_bus
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type rec_ff;

   assign emit_ready = !valid_ff || rsp_bus.ready;
   assign valid_in   = emit_valid || (valid_ff && !rsp_bus.ready);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (emit_valid && emit_ready) begin
         rec_ff <= emit_rec;
      end
   end

   assign rsp_bus.valid           = valid_ff;
   assign rsp_bus.kind            = rec_ff.kind;
   assign rsp_bus.proc_index      = rec_ff.proc_index;
   assign rsp_bus.seg_start       = rec_ff.seg_start;
   assign rsp_bus.seg_end         = rec_ff.seg_end;
   assign rsp_bus.arrival_echo    = rec_ff.arrival_echo;
   assign rsp_bus.burst_echo      = rec_ff.burst_echo;
   assign rsp_bus.priority_echo   = rec_ff.priority_echo;
   assign rsp_bus.finish_tick     = rec_ff.finish_tick;
   assign rsp_bus.turnaround      = rec_ff.turnaround;
   assign rsp_bus.waiting         = rec_ff.waiting;
   assign rsp_bus.response        = rec_ff.response;
   assign rsp_bus.end_of_run      = rec_ff.end_of_run;

endmodule

// ===== src/psch_seq.sv =====
// Scheduling sequencer: loads rows, scans the table, dispatches and emits records.
// Depends on psch_pkg and the load and register write channel interfaces.
module psch_seq
   import psch_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   psch_req_if.sink    req_bus,
   psch_csr_if.sink    csr_bus,
   output mem_req_type mreq,
   input  entry_type   rd_data,
   output logic        emit_valid,
   output rsp_type     emit_rec,
   input  logic        emit_ready
);

   state_type            state_ff, state_in;
   logic                 mode_ff, mode_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     done_ff, done_in;
   logic [TICK_W-1:0]    now_ff, now_in;
   logic [TICK_W-1:0]    seg_begin_ff, seg_begin_in;
   logic [IDX_W-1:0]     run_idx_ff, run_idx_in;
   logic                 run_vld_ff, run_vld_in;
   logic [MAX_PROCS-1:0] started_ff, started_in;
   logic [SUM_W-1:0]     sum_tat_ff, sum_tat_in;
   logic [SUM_W-1:0]     sum_wt_ff, sum_wt_in;
   logic [SUM_W-1:0]     sum_rsp_ff, sum_rsp_in;
   logic                 init_ff, init_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   entry_type            best_ff, best_in;
   logic                 na_vld_ff, na_vld_in;
   logic [TIME_W-1:0]    na_ff, na_in;
   logic [TIME_W-1:0]    min_ff, min_in;
   logic [TICK_W-1:0]    fin_ff, fin_in;
   logic [TIME_W-1:0]    delta_ff, delta_in;
   logic [CNT_W-1:0]     mi_ff, mi_in;

   logic                 load_beat;
   logic                 emit_beat;
   logic                 issue;
   logic                 scan_done;
   logic                 scan_begin;
   logic                 need_sw_seg;
   logic                 ready_e, better_e, future_e;
   logic [TICK_W-1:0]    gap;
   logic [TIME_W-1:0]    rem_left;
   logic [TIME_W-1:0]    load_burst;
   entry_type            plain_row;
   entry_type            run_row;

   assign load_beat   = req_bus.valid && req_bus.ready;
   assign emit_beat   = emit_valid && emit_ready;
   assign issue       = (state_ff == ST_SCAN) && (scan_ff < cnt_ff);
   assign scan_done   = (state_ff == ST_SCAN) && !issue && !rd_vld_ff;
   assign need_sw_seg = run_vld_ff && (run_idx_ff != best_idx_ff);
   assign csr_bus.ready = 1'b1;

   // entry returned by the scan read
   assign ready_e  = (rd_data.remaining != '0) && (TICK_W'(rd_data.arrival) <= now_ff);
   assign future_e = (rd_data.remaining != '0) && (TICK_W'(rd_data.arrival) > now_ff);
   assign better_e = !best_vld_ff || (rd_data.priority_num < best_ff.priority_num) ||
                     ((rd_data.priority_num == best_ff.priority_num) &&
                      (rd_data.arrival < best_ff.arrival));

   assign gap        = TICK_W'(na_ff) - now_ff;
   assign rem_left   = best_ff.remaining - delta_ff;
   assign load_burst = (req_bus.burst_len == '0) ? TIME_W'(1) : req_bus.burst_len;

   // row written at a non-preemptive dispatch
   always_comb begin
      plain_row           = best_ff;
      plain_row.first_run = now_ff;
      plain_row.finish    = fin_ff;
      plain_row.remaining = '0;
   end

   // row written after a preemptive run slice
   always_comb begin
      run_row           = best_ff;
      run_row.remaining = rem_left;
      run_row.finish    = now_ff + TICK_W'(delta_ff);
      if (!started_ff[best_idx_ff]) begin
         run_row.first_run = now_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (load_beat && req_bus.last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done && !init_ff) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (!mode_ff) begin
               state_in = best_vld_ff ? ST_SEG : ST_SCAN;
            end else if (best_vld_ff) begin
               state_in = ST_SWITCH;
            end else begin
               state_in = run_vld_ff ? ST_IDLE_SEG : ST_SCAN;
            end
         end
         ST_SEG: begin
            if (emit_beat) state_in = ST_MET;
         end
         ST_MET: begin
            if (emit_beat) state_in = (done_ff + 1'b1 == cnt_ff) ? ST_TOTAL : ST_SCAN;
         end
         ST_IDLE_SEG: begin
            if (emit_beat) state_in = ST_SCAN;
         end
         ST_SWITCH: begin
            if (!need_sw_seg || emit_beat) state_in = ST_RUN;
         end
         ST_RUN: begin
            if ((rem_left == '0) && (done_ff + 1'b1 == cnt_ff)) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_FLUSH: begin
            if (!run_vld_ff || emit_beat) state_in = ST_MRD;
         end
         ST_MRD: begin
            state_in = ST_MEMIT;
         end
         ST_MEMIT: begin
            if (emit_beat) state_in = (mi_ff + 1'b1 == cnt_ff) ? ST_TOTAL : ST_MRD;
         end
         ST_TOTAL: begin
            if (emit_beat) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs: load ready, table port, record beat
   always_comb begin
      req_bus.ready = (state_ff == ST_LOAD);
      mreq          = '0;
      emit_valid    = 1'b0;
      emit_rec      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            mreq.we                 = load_beat && (cnt_ff < CNT_W'(MAX_PROCS));
            mreq.waddr              = IDX_W'(cnt_ff);
            mreq.wdata.arrival      = req_bus.arrival_tick;
            mreq.wdata.burst        = load_burst;
            mreq.wdata.priority_num = req_bus.priority_req;
            mreq.wdata.remaining    = load_burst;
         end
         ST_SCAN: begin
            mreq.re    = issue;
            mreq.raddr = IDX_W'(scan_ff);
         end
         ST_SEG: begin
            emit_valid = 1'b1;
            emit_rec   = seg_rec(best_idx_ff, now_ff, fin_ff);
         end
         ST_MET: begin
            emit_valid = 1'b1;
            emit_rec   = met_rec(best_idx_ff, plain_row);
            mreq.we    = emit_beat;
            mreq.waddr = best_idx_ff;
            mreq.wdata = plain_row;
         end
         ST_IDLE_SEG, ST_FLUSH: begin
            emit_valid = run_vld_ff;
            emit_rec   = seg_rec(run_idx_ff, seg_begin_ff, now_ff);
         end
         ST_SWITCH: begin
            emit_valid = need_sw_seg;
            emit_rec   = seg_rec(run_idx_ff, seg_begin_ff, now_ff);
         end
         ST_RUN: begin
            mreq.we    = 1'b1;
            mreq.waddr = best_idx_ff;
            mreq.wdata = run_row;
         end
         ST_MRD: begin
            mreq.re    = 1'b1;
            mreq.raddr = IDX_W'(mi_ff);
         end
         ST_MEMIT: begin
            emit_valid = 1'b1;
            emit_rec   = met_rec(IDX_W'(mi_ff), rd_data);
         end
         ST_TOTAL: begin
            emit_valid = 1'b1;
            emit_rec   = tot_rec(sum_tat_ff, sum_wt_ff, sum_rsp_ff);
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      done_in      = done_ff;
      now_in       = now_ff;
      seg_begin_in = seg_begin_ff;
      run_idx_in   = run_idx_ff;
      run_vld_in   = run_vld_ff;
      started_in   = started_ff;
      sum_tat_in   = sum_tat_ff;
      sum_wt_in    = sum_wt_ff;
      sum_rsp_in   = sum_rsp_ff;
      init_in      = init_ff;
      scan_in      = scan_ff;
      rd_vld_in    = issue;
      rd_idx_in    = IDX_W'(scan_ff);
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      na_vld_in    = na_vld_ff;
      na_in        = na_ff;
      min_in       = min_ff;
      fin_in       = fin_ff;
      delta_in     = delta_ff;
      mi_in        = mi_ff;

      if (csr_bus.valid) mode_in = csr_bus.preemptive_mode;

      // fold one scanned row into best, next arrival and earliest arrival
      if (issue) scan_in = scan_ff + 1'b1;
      if (rd_vld_ff) begin
         if (ready_e && better_e) begin
            best_vld_in = 1'b1;
            best_idx_in = rd_idx_ff;
            best_in     = rd_data;
         end
         if (future_e && (!na_vld_ff || (rd_data.arrival < na_ff))) begin
            na_vld_in = 1'b1;
            na_in     = rd_data.arrival;
         end
         if (rd_data.arrival < min_ff) min_in = rd_data.arrival;
      end

      // totals accumulate on every metrics beat
      if (emit_beat && (emit_rec.kind == KIND_MET)) begin
         sum_tat_in = sum_tat_ff + emit_rec.turnaround;
         sum_wt_in  = sum_wt_ff + emit_rec.waiting;
         sum_rsp_in = sum_rsp_ff + emit_rec.response;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (load_beat && (cnt_ff < CNT_W'(MAX_PROCS))) cnt_in = cnt_ff + 1'b1;
            if (load_beat && req_bus.last) begin
               init_in = mode_ff;
               now_in  = '0;
            end
         end
         ST_SCAN: begin
            // first preemptive pass only finds the earliest arrival
            if (scan_done && init_ff) begin
               init_in      = 1'b0;
               now_in       = TICK_W'(min_ff);
               seg_begin_in = TICK_W'(min_ff);
            end
         end
         ST_DECIDE: begin
            fin_in = now_ff + TICK_W'(best_ff.burst);
            if ((gap < TICK_W'(best_ff.remaining)) && na_vld_ff) begin
               delta_in = TIME_W'(gap);
            end else begin
               delta_in = best_ff.remaining;
            end
            if (!best_vld_ff && (!mode_ff || !run_vld_ff)) begin
               now_in       = TICK_W'(na_ff);
               seg_begin_in = TICK_W'(na_ff);
            end
         end
         ST_MET: begin
            if (emit_beat) begin
               now_in  = fin_ff;
               done_in = done_ff + 1'b1;
            end
         end
         ST_IDLE_SEG: begin
            if (emit_beat) begin
               run_vld_in   = 1'b0;
               now_in       = TICK_W'(na_ff);
               seg_begin_in = TICK_W'(na_ff);
            end
         end
         ST_SWITCH: begin
            if (!run_vld_ff || need_sw_seg) begin
               if (!need_sw_seg || emit_beat) begin
                  seg_begin_in = now_ff;
                  run_idx_in   = best_idx_ff;
                  run_vld_in   = 1'b1;
               end
            end
         end
         ST_RUN: begin
            started_in[best_idx_ff] = 1'b1;
            now_in                  = now_ff + TICK_W'(delta_ff);
            if (rem_left == '0) done_in = done_ff + 1'b1;
         end
         ST_FLUSH: begin
            if (!run_vld_ff || emit_beat) begin
               run_vld_in = 1'b0;
               mi_in      = '0;
            end
         end
         ST_MEMIT: begin
            if (emit_beat) mi_in = mi_ff + 1'b1;
         end
         ST_TOTAL: begin
            if (emit_beat) begin
               cnt_in       = '0;
               done_in      = '0;
               now_in       = '0;
               seg_begin_in = '0;
               run_vld_in   = 1'b0;
               started_in   = '0;
               sum_tat_in   = '0;
               sum_wt_in    = '0;
               sum_rsp_in   = '0;
            end
         end
         default: begin
         end
      endcase

      // open a fresh scan pass
      scan_begin = (state_in == ST_SCAN) && ((state_ff != ST_SCAN) || scan_done);
      if (scan_begin) begin
         scan_in     = '0;
         best_vld_in = 1'b0;
         na_vld_in   = 1'b0;
         min_in      = '1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         mode_ff      <= 1'b0;
         cnt_ff       <= '0;
         done_ff      <= '0;
         now_ff       <= '0;
         seg_begin_ff <= '0;
         run_vld_ff   <= 1'b0;
         started_ff   <= '0;
         sum_tat_ff   <= '0;
         sum_wt_ff    <= '0;
         sum_rsp_ff   <= '0;
         init_ff      <= 1'b0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         best_vld_ff  <= 1'b0;
         na_vld_ff    <= 1'b0;
         mi_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         done_ff      <= done_in;
         now_ff       <= now_in;
         seg_begin_ff <= seg_begin_in;
         run_vld_ff   <= run_vld_in;
         started_ff   <= started_in;
         sum_tat_ff   <= sum_tat_in;
         sum_wt_ff    <= sum_wt_in;
         sum_rsp_ff   <= sum_rsp_in;
         init_ff      <= init_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         best_vld_ff  <= best_vld_in;
         na_vld_ff    <= na_vld_in;
         mi_ff        <= mi_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      run_idx_ff  <= run_idx_in;
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      na_ff       <= na_in;
      min_ff      <= min_in;
      fin_ff      <= fin_in;
      delta_ff    <= delta_in;
   end

endmodule

// ===== src/priority_scheduler.sv =====
// Priority scheduler top level: sequencer, process table RAM and output register.
// Depends on psch_pkg, psch_if, psch_table, psch_obuf and psch_seq.
//
// Load processes one beat per cycle on req_bus while the block is loading; the beat
// with last set starts a run on the stored set (at most 16 processes, extra loads
// are dropped). The user must write preemptive_mode over csr_bus only while the
// block is idle; the block itself does not enforce this. Every scheduling decision
// scans the process table through its single read port, one row per cycle, and
// then emits its record beats to rsp_bus; a preemptive slice passes through the
// switch and run states, a switch segment beat riding in the switch state, and a
// preemptive run adds one earliest-arrival scan up front and a table read per
// stored metrics record. No new load is taken until the totals record of the
// run has entered the output register. No clearing pass runs after reset.
module priority_scheduler
   import psch_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   psch_req_if.sink   req_bus,
   psch_rsp_if.source rsp_bus,
   psch_csr_if.sink   csr_bus
);

   mem_req_type mreq;
   entry_type   rd_data;
   logic        emit_valid;
   logic        emit_ready;
   rsp_type     emit_rec;

   psch_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .mreq       (mreq),
      .rd_data    (rd_data),
      .emit_valid (emit_valid),
      .emit_rec   (emit_rec),
      .emit_ready (emit_ready)
   );

   psch_table u_table (
      .clock   (clock),
      .mreq    (mreq),
      .rd_data (rd_data)
   );

   psch_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .emit_valid (emit_valid),
      .emit_rec   (emit_rec),
      .emit_ready (emit_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== src/psch_checker.sv =====
// Port-level checks of the priority scheduler, bound to the top level.
// Depends on psch_pkg and priority_scheduler.
module psch_checker
   import psch_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_last,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input kind_type          rsp_kind,
   input logic [TICK_W-1:0] rsp_seg_start,
   input logic [TICK_W-1:0] rsp_seg_end,
   input logic              rsp_end_of_run
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_seg_start) && $stable(rsp_seg_end))
      else $error("stalled result beat changed");

   // a run blocks further loads
   a_run_blocks_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("load taken right after the last process");

   // only the totals record closes a run
   a_eor_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_run |-> rsp_kind == KIND_TOT)
      else $error("end of run on a non-totals record");

   // segments are never empty
   a_seg_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SEG) |-> rsp_seg_end > rsp_seg_start)
      else $error("empty execution segment");

endmodule

bind priority_scheduler psch_checker u_psch_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_last       (req_bus.last),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_kind       (rsp_bus.kind),
   .rsp_seg_start  (rsp_bus.seg_start),
   .rsp_seg_end    (rsp_bus.seg_end),
   .rsp_end_of_run (rsp_bus.end_of_run)
);

// ===== tb/priority_scheduler_tb.sv =====
// Self-checking testbench for priority_scheduler: process loads, runs and mode writes.
// Depends on psch_pkg and the channel interfaces in psch_if; predicts every record itself.
module priority_scheduler_tb;
   import psch_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCH_LIMIT = 4000;
   localparam int SETTLE      = 40;
   localparam int ITEM_GOAL   = 320;

   logic clock;
   logic reset;

   psch_req_if req_bus ();
   psch_rsp_if rsp_bus ();
   psch_csr_if csr_bus ();

   priority_scheduler u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // scheduler shadow: process table, clock and sums
   int unsigned       sh_arrival [MAX_PROCS];
   int unsigned       sh_burst   [MAX_PROCS];
   int unsigned       sh_prio    [MAX_PROCS];
   int unsigned       sh_left    [MAX_PROCS];
   int unsigned       sh_first   [MAX_PROCS];
   int unsigned       sh_finish  [MAX_PROCS];
   bit                sh_started [MAX_PROCS];
   int                sh_count;
   int unsigned       sh_now;
   int unsigned       sum_tat, sum_wt, sum_rsp;
   bit                sh_preempt;

   rsp_type expected_recs[$];

   int  error_count;
   int  items_sent;
   int  recs_checked;
   int  runs_plain, runs_preempt;
   int  burst_left;
   int  idle_cycles;
   int  rx_cycle;
   int  rx_pattern;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // append one expected record, masked to the field widths
   task automatic add_rec(kind_type k, int unsigned idx, int unsigned s, int unsigned e,
                          int unsigned arr, int unsigned bur, int unsigned pri,
                          int unsigned comp, int unsigned tat, int unsigned wt,
                          int unsigned rs, bit eor);
      rsp_type r;
      r                 = '0;
      r.kind            = k;
      r.proc_index      = PIDX_W'(idx);
      r.seg_start       = TICK_W'(s);
      r.seg_end         = TICK_W'(e);
      r.arrival_echo    = TIME_W'(arr);
      r.burst_echo      = TIME_W'(bur);
      r.priority_echo   = PRI_W'(pri);
      r.finish_tick     = TICK_W'(comp);
      r.turnaround      = SUM_W'(tat);
      r.waiting         = SUM_W'(wt);
      r.response        = SUM_W'(rs);
      r.end_of_run      = eor;
      expected_recs     = {expected_recs, r};
   endtask

   task automatic add_metrics(int i);
      int unsigned tat, wt, rs;
      tat = sh_finish[i] - sh_arrival[i];
      wt  = tat - sh_burst[i];
      rs  = sh_first[i] - sh_arrival[i];
      add_rec(KIND_MET, i, sh_first[i], 0, sh_arrival[i], sh_burst[i], sh_prio[i],
              sh_finish[i], tat, wt, rs, 1'b0);
      sum_tat = (sum_tat + tat) & 32'h1FF_FFFF;
      sum_wt  = (sum_wt + wt) & 32'h1FF_FFFF;
      sum_rsp = (sum_rsp + rs) & 32'h1FF_FFFF;
   endtask

   // best ready process: lowest priority number, then earliest arrival, then load order
   function automatic int best_ready();
      int best;
      best = -1;
      for (int i = 0; i < sh_count; i++) begin
         if (sh_left[i] == 0 || sh_arrival[i] > sh_now) continue;
         if (best < 0 || sh_prio[i] < sh_prio[best] ||
             (sh_prio[i] == sh_prio[best] && sh_arrival[i] < sh_arrival[best]))
            best = i;
      end
      return best;
   endfunction

   function automatic int unsigned next_arrival();
      int unsigned t;
      t = 32'hFFFF_FFFF;
      for (int i = 0; i < sh_count; i++)
         if (sh_left[i] != 0 && sh_arrival[i] > sh_now && sh_arrival[i] < t)
            t = sh_arrival[i];
      return t;
   endfunction

   // store one accepted load; on the final one, schedule the set and queue every record
   task automatic predict_load(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bur,
                               logic [PRI_W-1:0] pri, logic lst);
      int          done, idx, run;
      int unsigned na, delta, segb;
      if (sh_count < MAX_PROCS) begin
         sh_arrival[sh_count] = 32'(arr);
         sh_burst[sh_count]   = (bur == '0) ? 32'd1 : 32'(bur);
         sh_prio[sh_count]    = 32'(pri);
         sh_left[sh_count]    = sh_burst[sh_count];
         sh_started[sh_count] = 1'b0;
         sh_count++;
      end
      if (!lst) return;
      done = 0;
      if (!sh_preempt) begin
         runs_plain++;
         sh_now = 0;
         while (done < sh_count) begin
            idx = best_ready();
            if (idx < 0) begin
               sh_now = next_arrival();
               continue;
            end
            sh_first[idx]  = sh_now;
            sh_finish[idx] = sh_now + sh_burst[idx];
            add_rec(KIND_SEG, idx, sh_now, sh_finish[idx], 0, 0, 0, 0, 0, 0, 0, 1'b0);
            add_metrics(idx);
            sh_now       = sh_finish[idx];
            sh_left[idx] = 0;
            done++;
         end
      end else begin
         runs_preempt++;
         sh_now = 32'hFFFF_FFFF;
         for (int i = 0; i < sh_count; i++)
            if (sh_arrival[i] < sh_now) sh_now = sh_arrival[i];
         run  = -1;
         segb = sh_now;
         while (done < sh_count) begin
            idx = best_ready();
            if (idx < 0) begin
               if (run >= 0) add_rec(KIND_SEG, run, segb, sh_now, 0, 0, 0, 0, 0, 0, 0, 1'b0);
               run    = -1;
               sh_now = next_arrival();
               segb   = sh_now;
               continue;
            end
            if (!sh_started[idx]) begin
               sh_started[idx] = 1'b1;
               sh_first[idx]   = sh_now;
            end
            if (idx != run) begin
               if (run >= 0) add_rec(KIND_SEG, run, segb, sh_now, 0, 0, 0, 0, 0, 0, 0, 1'b0);
               segb = sh_now;
               run  = idx;
            end
            // run until the next arrival or completion, whichever is first
            na    = next_arrival();
            delta = sh_left[idx];
            if (na != 32'hFFFF_FFFF && na - sh_now < delta) delta = na - sh_now;
            sh_left[idx] -= delta;
            sh_now       += delta;
            if (sh_left[idx] == 0) begin
               sh_finish[idx] = sh_now;
               done++;
            end
         end
         if (run >= 0) add_rec(KIND_SEG, run, segb, sh_now, 0, 0, 0, 0, 0, 0, 0, 1'b0);
         for (int i = 0; i < sh_count; i++) add_metrics(i);
      end
      add_rec(KIND_TOT, 0, 0, 0, 0, 0, 0, 0, sum_tat, sum_wt, sum_rsp, 1'b1);
      sh_count = 0;
      sum_tat  = 0;
      sum_wt   = 0;
      sum_rsp  = 0;
   endtask

   // send one load beat; idle gaps open between random-length bursts
   task automatic send_load(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bur,
                            logic [PRI_W-1:0] pri, logic lst);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid        <= 1'b1;
      req_bus.arrival_tick <= arr;
      req_bus.burst_len    <= bur;
      req_bus.priority_req <= pri;
      req_bus.last         <= lst;
      do @(posedge clock); while (!req_bus.ready);
      predict_load(arr, bur, pri, lst);
      burst_left--;
      items_sent++;
   endtask

   // hold off until every expected record is in, then let the block settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_recs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mode(bit mode);
      drain();
      csr_bus.valid           <= 1'b1;
      csr_bus.preemptive_mode <= mode;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sh_preempt = mode;
   endtask

   // lone processes at the field extremes, and a zero burst
   task automatic test_extremes();
      write_mode(1'b0);
      send_load(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
      send_load(16'h0000, 16'h0001, 8'h00, 1'b1);
      send_load(16'h5555, 16'h0000, 8'hAA, 1'b1);
      write_mode(1'b1);
      send_load(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
      send_load(16'hAAAA, 16'h0000, 8'h55, 1'b1);
   endtask

   // priority ties, equal arrivals, an idle gap and a preempting arrival, in both modes
   task automatic test_ties(bit mode);
      write_mode(mode);
      send_load(16'd2,  16'd5, 8'd3, 1'b0);
      send_load(16'd2,  16'd4, 8'd3, 1'b0);
      send_load(16'd0,  16'd3, 8'd3, 1'b0);
      send_load(16'd4,  16'd2, 8'd1, 1'b0);
      send_load(16'd40, 16'd6, 8'd0, 1'b1);
   endtask

   // more loads than table rows; the extras drop and the final one still starts the run
   task automatic test_table_full();
      write_mode(1'b1);
      for (int i = 0; i < MAX_PROCS + 2; i++)
         send_load(16'($urandom_range(0, 30)), 16'($urandom_range(1, 9)),
                   8'($urandom_range(0, 4)), i == MAX_PROCS + 1);
   endtask

   // random process sets, mostly small, with mode changes and one full pause
   task automatic test_random();
      int  size, arr_span, bur_span, pri_span;
      bit  paused;
      paused = 1'b0;
      while (items_sent < ITEM_GOAL) begin
         if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
         if (!paused && items_sent > ITEM_GOAL / 2) begin
            drain();
            paused = 1'b1;
         end
         case ($urandom_range(0, 19))
            0:       size = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 3);
            1, 2, 3: size = $urandom_range(7, MAX_PROCS);
            default: size = $urandom_range(1, 6);
         endcase
         arr_span = ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(0, 40);
         bur_span = ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(1, 12);
         pri_span = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 3);
         for (int i = 0; i < size; i++)
            send_load(16'($urandom_range(0, arr_span)), 16'($urandom_range(1, bur_span)),
                      8'($urandom_range(0, pri_span)), i == size - 1);
      end
   endtask

   // reset and stimulus
   initial begin
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.arrival_tick    = '0;
      req_bus.burst_len       = '0;
      req_bus.priority_req    = '0;
      req_bus.last            = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.preemptive_mode = 1'b0;
      sh_count   = 0;
      sum_tat    = 0;
      sum_wt     = 0;
      sum_rsp    = 0;
      sh_preempt = 1'b0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_ties(1'b0);
      test_ties(1'b1);
      test_table_full();
      test_random();
      req_bus.valid <= 1'b0;
      while (expected_recs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d loads in %0d run-to-completion and %0d preemptive runs,",
               items_sent, runs_plain, runs_preempt);
      $display("checking %0d result records field by field.", recs_checked);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // result stalls: always ready, random, or periodic, switching now and then
   initial begin
      rsp_bus.ready = 1'b0;
      rx_cycle      = 0;
      rx_pattern    = 0;
   end

   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_pattern = $urandom_range(0, 2);
      case (rx_pattern)
         0:       rsp_bus.ready <= 1'b1;
         1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
         default: rsp_bus.ready <= (rx_cycle % 5) != 0;
      endcase
   end

   function automatic bit field_ok(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // compare each result beat with the oldest expected record
   always @(posedge clock) begin
      rsp_type e;
      bit      ok;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_recs.size() == 0) begin
            $error("result beat with no record expected");
            error_count++;
         end else begin
            e  = expected_recs.pop_front();
            ok = field_ok("kind", 64'(e.kind), 64'(rsp_bus.kind))
               & field_ok("proc_index", 64'(e.proc_index), 64'(rsp_bus.proc_index))
               & field_ok("seg_start", 64'(e.seg_start), 64'(rsp_bus.seg_start))
               & field_ok("seg_end", 64'(e.seg_end), 64'(rsp_bus.seg_end))
               & field_ok("arrival_echo", 64'(e.arrival_echo), 64'(rsp_bus.arrival_echo))
               & field_ok("burst_echo", 64'(e.burst_echo), 64'(rsp_bus.burst_echo))
               & field_ok("priority_echo", 64'(e.priority_echo),
                          64'(rsp_bus.priority_echo))
               & field_ok("finish_tick", 64'(e.finish_tick), 64'(rsp_bus.finish_tick))
               & field_ok("turnaround", 64'(e.turnaround), 64'(rsp_bus.turnaround))
               & field_ok("waiting", 64'(e.waiting), 64'(rsp_bus.waiting))
               & field_ok("response", 64'(e.response), 64'(rsp_bus.response))
               & field_ok("end_of_run", 64'(e.end_of_run), 64'(rsp_bus.end_of_run));
            if (!ok) error_count++;
            recs_checked++;
         end
      end
   end

   // watchdog: end the run after too long without any beat on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
